// ===== src/brig_pkg.sv =====
package brig_pkg;

    localparam int TW_N = 624;
    localparam int TW_M = 397;
    localparam int IDX_W = 10;
    localparam logic [31:0] TW_MATRIX = 32'h9908_b0df;
    localparam logic [31:0] SEED_RESET = 32'd5489;
    localparam logic [31:0] INIT_MULT = 32'd1812433253;
    localparam int MAX_COUNT_DEF = 64;
    localparam int CNT_W = 7;
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_SEED = 3'd0;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PREP,
        S_THRESH,
        S_TWIST,
        S_DRAW,
        S_CHECK,
        S_MOD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic init_start;
        logic init_step;
        logic load_req;
        logic thresh_start;
        logic twist_start;
        logic twist_step;
        logic draw_read;
        logic mod_start;
        logic div_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic init_done;
        logic twist_done;
        logic need_twist;
        logic div_done;
        logic reject;
        logic last_value;
        logic no_count;
    } t_status;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & 32'h9d2c_5680);
        y = y ^ ((y << 15) & 32'hefc6_0000);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== src/brig_ctrl.sv =====
module brig_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_out_stall,
    input  logic              i_seed_wr,
    input  brig_pkg::t_status i_status,
    output brig_pkg::t_cmd    o_cmd,
    output logic              o_stall,
    output logic              o_valid
);
    import brig_pkg::*;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && i_out_stall;
        o_cmd = '0;
        o_stall = 1'b1;
        case (r_state)
            S_INIT: begin
                o_cmd.init_step = 1'b1;
                if (i_status.init_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_seed_wr) begin
                    o_stall = 1'b1;
                    o_cmd.init_start = 1'b1;
                    n_state = S_INIT;
                end else if (i_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (i_status.no_count) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.thresh_start = 1'b1;
                    n_state = S_THRESH;
                end
            end
            S_THRESH: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_DRAW;
                end
            end
            S_DRAW: begin
                if (i_status.need_twist) begin
                    o_cmd.twist_start = 1'b1;
                    n_state = S_TWIST;
                end else begin
                    o_cmd.draw_read = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_TWIST: begin
                o_cmd.twist_step = 1'b1;
                if (i_status.twist_done) begin
                    n_state = S_DRAW;
                end
            end
            S_CHECK: begin
                if (i_status.reject) begin
                    n_state = S_DRAW;
                end else begin
                    o_cmd.mod_start = 1'b1;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!(r_valid && i_out_stall)) begin
                    o_cmd.emit = 1'b1;
                    n_valid = 1'b1;
                    n_state = i_status.last_value ? S_IDLE : S_DRAW;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_valid = r_valid;

endmodule

// ===== src/brig_data.sv =====
module brig_data #(
    parameter int MAX_COUNT = brig_pkg::MAX_COUNT_DEF
) (
    input  logic                   i_clk,
    input  brig_pkg::t_cmd         i_cmd,
    input  logic [31:0]            i_seed,
    input  logic [31:0]            i_range_low,
    input  logic [31:0]            i_range_high,
    input  logic [brig_pkg::CNT_W-1:0] i_count,
    output brig_pkg::t_status      o_status,
    output logic [31:0]            o_value,
    output logic                   o_last
);
    import brig_pkg::*;

    logic [31:0] r_mem [TW_N];
    logic [31:0] r_rd;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_ptr;
    logic [1:0]  r_ph;
    logic [31:0] r_prev;
    logic [31:0] r_a, r_b;
    logic [31:0] r_lo, r_range, r_thresh, r_draw;
    logic [CNT_W-1:0] r_left;
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic [5:0]  r_bit;
    logic        r_busy_div;
    logic        r_for_thresh;
    logic        r_init_done, r_twist_done;
    logic [31:0] r_mult;
    logic [31:0] r_value;
    logic        r_last;

    logic [IDX_W-1:0] w_p1, w_pm, w_addr, w_nxt;
    logic [31:0] w_y, w_v;
    logic [32:0] w_sh, w_sub;
    logic [CNT_W-1:0] w_cnt;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input int b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + (IDX_W+1)'(b);
        if (s >= (IDX_W+1)'(TW_N)) begin
            s = s - (IDX_W+1)'(TW_N);
        end
        return s[IDX_W-1:0];
    endfunction

    assign w_p1 = wrap_add(r_ptr, 1);
    assign w_pm = wrap_add(r_ptr, TW_M);
    assign w_nxt = r_ptr + IDX_W'(1);
    assign w_y = (r_a & 32'h8000_0000) | (r_b & 32'h7fff_ffff);
    assign w_v = r_rd ^ (w_y >> 1) ^ (w_y[0] ? TW_MATRIX : 32'd0);
    assign w_sh = {r_rem[31:0], r_quo[31]};
    assign w_sub = w_sh - {1'b0, r_dvs};
    assign w_cnt = (i_count > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : i_count;

    always_comb begin
        w_addr = r_ptr;
        if (i_cmd.twist_step) begin
            case (r_ph)
                2'd0: w_addr = w_p1;
                2'd1: w_addr = w_pm;
                default: w_addr = r_ptr;
            endcase
        end else if (i_cmd.draw_read) begin
            w_addr = r_idx;
        end
    end

    // Init handles each word as a multiply, then a write; twist as two fetches, then a write.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_addr];
        r_init_done <= 1'b0;
        r_twist_done <= 1'b0;
        if (i_cmd.init_start) begin
            r_mem[0] <= i_seed;
            r_prev <= i_seed;
            r_ptr <= IDX_W'(1);
            r_ph <= 2'd0;
            r_idx <= IDX_W'(TW_N);
        end else if (i_cmd.init_step && !r_init_done) begin
            if (r_ph == 2'd0) begin
                r_mult <= INIT_MULT * (r_prev ^ (r_prev >> 30));
                r_ph <= 2'd1;
            end else begin
                r_prev <= r_mult + 32'(r_ptr);
                r_mem[r_ptr] <= r_mult + 32'(r_ptr);
                r_ph <= 2'd0;
                r_ptr <= w_nxt;
                if (r_ptr == IDX_W'(TW_N - 1)) begin
                    r_init_done <= 1'b1;
                end
            end
        end
        if (i_cmd.twist_start) begin
            r_ptr <= '0;
            r_ph <= 2'd3;
        end else if (i_cmd.twist_step && !r_twist_done) begin
            case (r_ph)
                2'd3: r_ph <= 2'd0;
                2'd0: begin
                    if (r_ptr == '0) begin
                        r_a <= r_rd;
                    end
                    r_ph <= 2'd1;
                end
                2'd1: begin
                    r_b <= r_rd;
                    r_ph <= 2'd2;
                end
                default: begin
                    r_mem[r_ptr] <= w_v;
                    r_a <= r_b;
                    r_ptr <= w_nxt;
                    r_ph <= 2'd0;
                    if (r_ptr == IDX_W'(TW_N - 1)) begin
                        r_twist_done <= 1'b1;
                        r_idx <= '0;
                    end
                end
            endcase
        end
        if (i_cmd.draw_read) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.load_req) begin
            if ($signed(i_range_low) > $signed(i_range_high)) begin
                r_lo <= i_range_high;
                r_range <= i_range_low - i_range_high + 32'd1;
            end else begin
                r_lo <= i_range_low;
                r_range <= i_range_high - i_range_low + 32'd1;
            end
            r_left <= w_cnt;
        end
        if (i_cmd.thresh_start) begin
            r_quo <= 32'd0 - r_range;
            r_dvs <= r_range;
            r_rem <= '0;
            r_bit <= '0;
            r_for_thresh <= 1'b1;
            r_busy_div <= 1'b1;
        end
        if (i_cmd.mod_start) begin
            r_quo <= temper(r_rd);
            r_dvs <= r_range;
            r_rem <= '0;
            r_bit <= '0;
            r_for_thresh <= 1'b0;
            r_busy_div <= 1'b1;
        end
        if (i_cmd.div_step && r_busy_div) begin
            if (r_bit == 6'd32) begin
                r_busy_div <= 1'b0;
                if (r_for_thresh) begin
                    r_thresh <= (r_range == 32'd0) ? 32'd0 : r_rem[31:0];
                end else begin
                    r_draw <= (r_range == 32'd0) ? r_draw : r_rem[31:0] + r_lo;
                end
            end else begin
                r_rem <= w_sub[32] ? w_sh : w_sub;
                r_quo <= {r_quo[30:0], 1'b0};
                r_bit <= r_bit + 6'd1;
            end
        end
        if (i_cmd.mod_start) begin
            r_draw <= temper(r_rd);
        end
        if (i_cmd.emit) begin
            r_value <= r_draw;
            r_last <= (r_left == CNT_W'(1));
            r_left <= r_left - CNT_W'(1);
        end
    end

    // Each twist step fetches word i+1, then word i+M, then writes word i; word i itself
    // is carried over from the previous step.
    always_comb begin
        o_status.init_done = r_init_done;
        o_status.twist_done = r_twist_done;
        o_status.need_twist = (r_idx >= IDX_W'(TW_N));
        o_status.div_done = r_busy_div && (r_bit == 6'd32);
        o_status.reject = temper(r_rd) < r_thresh;
        o_status.last_value = (r_left == CNT_W'(1)) || (r_left == '0);
        o_status.no_count = (r_left == '0);
    end

    assign o_value = r_value;
    assign o_last = r_last;

endmodule

// ===== src/bounded_random_integer_generator.sv =====
// A request is served by its prepare step, threshold divide, draw and check, remainder divide
// and output; each rejected draw repeats the draw and check. Each further word repeats draw
// and check, remainder divide and output; a twist runs every 624 draws, and the first draw
// after reset or a seed write twists. A zero count returns to idle from prepare without drawing.
// Throughput is one request at a time; the shared serial divider sets the rate.
// Reset loads seed 5489 and runs initialization before input is taken.
module bounded_random_integer_generator #(
    parameter int MAX_COUNT = brig_pkg::MAX_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brig_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [31:0]          i_range_low,
    input  logic signed [31:0]          i_range_high,
    input  logic [brig_pkg::CNT_W-1:0]  i_count,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [31:0]          o_value,
    output logic                        o_last
);
    import brig_pkg::*;

    logic [31:0] r_seed;
    logic        r_pend;
    t_cmd        w_cmd;
    t_status     w_status;
    logic        w_wr;
    logic [31:0] w_value;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite && (paddr == ADDR_SEED);
    assign prdata = (paddr == ADDR_SEED) ? r_seed : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_RESET;
            r_pend <= 1'b1;
        end else begin
            if (w_wr) begin
                r_seed <= pwdata;
                r_pend <= 1'b1;
            end else if (w_cmd.init_start) begin
                r_pend <= 1'b0;
            end
        end
    end

    brig_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_stall(i_stall),
        .i_seed_wr  (r_pend),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_stall    (o_stall),
        .o_valid    (o_valid)
    );

    brig_data #(.MAX_COUNT(MAX_COUNT)) u_data (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_seed      (r_seed),
        .i_range_low (i_range_low),
        .i_range_high(i_range_high),
        .i_count     (i_count),
        .o_status    (w_status),
        .o_value     (w_value),
        .o_last      (o_last)
    );

    assign o_value = w_value;

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import brig_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic [31:0]    lo;
        logic [31:0]    hi;
        logic [CNT_W-1:0] cnt;
        bit             known;
        logic [31:0]    first_value;
    } t_request;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [31:0]     i_range_low;
    logic signed [31:0]     i_range_high;
    logic [CNT_W-1:0]       i_count;
    logic                   o_valid;
    logic                   i_stall;
    logic signed [31:0]     o_value;
    logic                   o_last;

    bounded_random_integer_generator dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_range_low(i_range_low),
        .i_range_high(i_range_high),
        .i_count(i_count),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_value(o_value),
        .o_last(o_last)
    );

    logic [31:0] twister [0:TW_N-1];
    int          twister_pos;

    logic [31:0] value_q [$];
    bit          last_q [$];
    t_request    known_q [$];

    int  err_cnt;
    int  cycle_cnt;
    int  accepted_cnt;
    int  value_cnt;
    int  seed_cnt;
    int  sender_idle_pct;
    int  receiver_stall_pct;
    int  hold_left;
    logic hold_start;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void twister_seed(logic [31:0] s);
        logic [31:0] p;
        twister[0] = s;
        for (int i = 1; i < TW_N; i++) begin
            p = twister[i-1];
            twister[i] = 32'd1812433253 * (p ^ (p >> 30)) + i;
        end
        twister_pos = TW_N;
    endfunction

    function automatic logic [31:0] twister_next();
        logic [31:0] y;
        logic [31:0] v;
        if (twister_pos >= TW_N) begin
            for (int i = 0; i < TW_N; i++) begin
                y = (twister[i] & 32'h8000_0000) | (twister[(i + 1) % TW_N] & 32'h7fff_ffff);
                v = twister[(i + TW_M) % TW_N] ^ (y >> 1);
                if (y[0]) begin
                    v = v ^ 32'h9908_b0df;
                end
                twister[i] = v;
            end
            twister_pos = 0;
        end
        y = twister[twister_pos];
        twister_pos++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9d2c_5680);
        y = y ^ ((y << 15) & 32'hefc6_0000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic void predict_values(logic [31:0] lo_in, logic [31:0] hi_in,
                                           logic [CNT_W-1:0] cnt);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] span;
        logic [31:0] cutoff;
        logic [31:0] d;
        int n;
        lo = lo_in;
        hi = hi_in;
        if ($signed(lo) > $signed(hi)) begin
            lo = hi_in;
            hi = lo_in;
        end
        n = (cnt > MAX_COUNT_DEF) ? MAX_COUNT_DEF : cnt;
        span = hi - lo + 32'd1;
        cutoff = (span != 0) ? ((32'd0 - span) % span) : 32'd0;
        for (int k = 0; k < n; k++) begin
            do begin
                d = twister_next();
            end while (d < cutoff);
            value_q = {value_q, ((span == 0) ? d : lo + (d % span))};
            last_q = {last_q, bit'(k == n - 1)};
        end
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at cycle %0d", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_request r;
        int first;
        if (i_rst_n && o_valid && !i_stall) begin
            if (value_q.size() == 0) begin
                report_mismatch("unexpected word", o_value, 32'd0);
            end else begin
                if (o_value !== value_q[0]) begin
                    report_mismatch("value", o_value, value_q[0]);
                end
                if (o_last !== last_q[0]) begin
                    report_mismatch("last", {31'd0, o_last}, {31'd0, last_q[0]});
                end
                void'(value_q.pop_front());
                void'(last_q.pop_front());
                value_cnt++;
            end
        end
        if (i_rst_n && i_valid && !o_stall) begin
            r = known_q.pop_front();
            first = value_q.size();
            predict_values(i_range_low, i_range_high, i_count);
            if (r.known && value_q.size() > first) begin
                value_q[first] = r.first_value;
            end
            accepted_cnt++;
        end
    end

    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left <= 3000;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(t_request r);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        known_q = {known_q, r};
        i_valid <= 1'b1;
        i_range_low <= r.lo;
        i_range_high <= r.hi;
        i_count <= r.cnt;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (value_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_SEED) begin
            twister_seed(data);
            seed_cnt++;
        end
    endtask

    function automatic t_request make_request(logic [31:0] lo, logic [31:0] hi,
                                              logic [CNT_W-1:0] cnt);
        t_request r;
        r.lo = lo;
        r.hi = hi;
        r.cnt = cnt;
        r.known = 1'b0;
        r.first_value = 32'd0;
        return r;
    endfunction

    function automatic t_request random_request();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [CNT_W-1:0] cnt;
        int pick;
        lo = $urandom;
        pick = $urandom_range(99);
        if (pick < 35) begin
            hi = lo + $urandom_range(1000);
        end else if (pick < 45) begin
            hi = lo;
        end else if (pick < 50) begin
            lo = 32'h8000_0000;
            hi = 32'h7fff_ffff;
        end else if (pick < 55) begin
            hi = lo - $urandom_range(50);
        end else begin
            hi = $urandom;
        end
        pick = $urandom_range(99);
        if (pick < 85) begin
            cnt = CNT_W'($urandom_range(6, 1));
        end else if (pick < 95) begin
            cnt = CNT_W'($urandom_range(MAX_COUNT_DEF, 1));
        end else begin
            cnt = (pick < 97) ? CNT_W'(0) : CNT_W'($urandom_range(127, MAX_COUNT_DEF + 1));
        end
        return make_request(lo, hi, cnt);
    endfunction

    t_request directed [13];

    initial begin
        logic [31:0] phase_seed [4];
        int phase_idle [4];
        int phase_stall [4];
        err_cnt = 0;
        accepted_cnt = 0;
        value_cnt = 0;
        seed_cnt = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        i_rst_n <= 1'b0;
        hold_start <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        i_valid <= 1'b0;
        i_stall <= 1'b0;
        i_range_low <= '0;
        i_range_high <= '0;
        i_count <= '0;
        twister_seed(SEED_RESET);

        directed[0] = make_request(32'h8000_0000, 32'h7fff_ffff, 7'd1);
        directed[0].known = 1'b1;
        directed[0].first_value = 32'hd091_bb5c;
        directed[1] = make_request(32'h7fff_ffff, 32'h7fff_ffff, 7'd3);
        directed[1].known = 1'b1;
        directed[1].first_value = 32'h7fff_ffff;
        directed[2] = make_request(32'h8000_0000, 32'h8000_0000, 7'd2);
        directed[2].known = 1'b1;
        directed[2].first_value = 32'h8000_0000;
        directed[3] = make_request(32'd5, -32'sd5, 7'd4);
        directed[4] = make_request(32'd0, 32'd10, 7'd0);
        directed[5] = make_request(-32'sd100, 32'd100, 7'd127);
        directed[6] = make_request(32'd0, 32'd1, 7'd65);
        directed[7] = make_request(32'd0, 32'h7fff_ffff, 7'd64);
        directed[8] = make_request(32'h8000_0000, 32'd0, 7'd2);
        directed[9] = make_request(32'hffff_ffff, 32'd0, 7'd5);
        directed[10] = make_request(32'd0, 32'h4000_0000, 7'd8);
        directed[11] = make_request(32'h7fff_ffff, 32'h8000_0000, 7'd2);
        directed[12] = make_request(32'd1, 32'd2, 7'd1);

        phase_seed = '{32'd0, 32'hffff_ffff, 32'd5489, $urandom};
        phase_idle = '{0, 50, 0, 9};
        phase_stall = '{0, 0, 50, 9};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_request(directed[i]);
        end
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            write_reg(3'd4, $urandom);
            write_reg(ADDR_SEED, phase_seed[p]);
            sender_idle_pct = phase_idle[p];
            receiver_stall_pct = phase_stall[p];
            for (int n = 0; n < 112; n++) begin
                if (p == 0 && n == 10) begin
                    hold_start <= 1'b1;
                    @(posedge i_clk);
                    hold_start <= 1'b0;
                end
                if (p == 1 && n == 50) begin
                    wait_idle();
                end
                send_request(random_request());
            end
            wait_idle();
        end

        $display("Ran %0d requests giving %0d values over %0d seeds,", accepted_cnt,
                 value_cnt, seed_cnt);
        $display("with idle and stall mixes, a long output hold-off and a drain pause.");
        if (err_cnt == 0 && value_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
